// ===== rtl/bmpu_pkg.sv =====
package bmpu_pkg;

  localparam int MAX_BONES = 64;
  localparam int FRAC_BITS = 16;
  localparam int BONE_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int GS_DEPTH = MAX_BONES * 16;
  localparam int GS_AW = $clog2(GS_DEPTH);
  localparam int ACC_W = 68;

  localparam logic CMD_LOCAL = 1'b0;
  localparam logic CMD_BIND  = 1'b1;

  // Floor shift by FRAC_BITS of an exact accumulator, then saturate to 32 bits.
  function automatic logic signed [31:0] sat_shift(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> FRAC_BITS;
    if (sh > $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff}))
      return 32'sh7fffffff;
    else if (sh < $signed({{(ACC_W-32){1'b1}}, 32'h80000000}))
      return 32'sh80000000;
    else
      return sh[31:0];
  endfunction

endpackage

// ===== rtl/bmpu_if.sv =====
interface bmpu_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  bone;
  logic signed [6:0] parent;
  logic [1:0]  row;
  logic signed [31:0] elem0;
  logic signed [31:0] elem1;
  logic signed [31:0] elem2;
  logic signed [31:0] elem3;
  modport source (output valid, cmd, bone, parent, row, elem0, elem1, elem2, elem3,
                  input ready);
  modport sink (input valid, cmd, bone, parent, row, elem0, elem1, elem2, elem3,
                output ready);
endinterface

interface bmpu_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_bone;
  logic [1:0]  out_row;
  logic signed [31:0] val0;
  logic signed [31:0] val1;
  logic signed [31:0] val2;
  logic signed [31:0] val3;
  logic        last_row;
  logic        parent_error;
  modport source (output valid, out_bone, out_row, val0, val1, val2, val3, last_row,
                  parent_error, input ready);
  modport sink (input valid, out_bone, out_row, val0, val1, val2, val3, last_row,
                parent_error, output ready);
endinterface

// ===== rtl/bone_matrix_palette_update.sv =====
// Bone matrix palette update. Each bone is loaded as eight row transfers (four local
// rows, then four bind rows, ascending bone order); the bind row 3 transfer carries the
// parent and starts the work. One shared 32x32 multiply-accumulate unit then forms the
// global matrix (64 products, skipped for a root) and the skinning matrix (64 products).
// Each output element is four products issued in turn, then the sum settles and is
// saturated. After its last row a bone keeps the input not ready through the global
// matrix pass (for a root, a copy of the local matrix instead), the skinning matrix
// pass and the result transfers, including every cycle a result waits for the
// receiver. Four result rows follow, row 0 first; each row is computed only after the
// previous one has been taken. An out-of-range or not yet computed parent sets
// parent_error and is treated as a root. Storage for globals is a single-port-write
// RAM of MAX_BONES*16 words.
module bone_matrix_palette_update
  import bmpu_pkg::*;
(
  input logic clk,
  input logic rst_n,
  bmpu_in_if.sink    in_ch,
  bmpu_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_GLOB, S_SKIN, S_OUT} state_t;

  state_t state_r;
  logic signed [31:0] loc_r  [16];
  logic signed [31:0] bind_r [16];
  logic signed [31:0] glob_r [16];
  logic signed [31:0] srow_r [4];
  logic [MAX_BONES-1:0] done_r;
  logic [5:0] bone_r;
  logic [6:0] par_r;
  logic       err_r;
  logic       root_r;
  // Element counters: r, c, k and a small phase counter.
  logic [1:0] r_r, c_r, k_r;
  logic [2:0] ph_r;
  logic       out_v_r;

  logic acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = rst_n && (state_r == S_IDLE);

  // Global store RAM: read parent row element, write new globals.
  logic             gs_we;
  logic [GS_AW-1:0] gs_waddr, gs_raddr;
  logic [31:0]      gs_wdata, gs_rdata;

  bmpu_ram #(.WIDTH(32), .DEPTH(GS_DEPTH)) u_gs (
    .clk(clk), .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata),
    .raddr(gs_raddr), .rdata(gs_rdata)
  );

  // MAC operand selection. Phase 0 issues the RAM read, phase 1 the product.
  logic mac_en, mac_clr;
  logic signed [31:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] acc;

  bmpu_mac u_mac (
    .clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b), .acc_r(acc)
  );

  assign gs_raddr = GS_AW'({par_r[BONE_W-1:0], r_r, k_r});
  assign mac_en   = (state_r == S_GLOB || state_r == S_SKIN) && ph_r == 3'd1;
  assign mac_clr  = mac_en && k_r == 2'd0;
  assign mac_a    = (state_r == S_GLOB) ? $signed(gs_rdata) : glob_r[{r_r, k_r}];
  assign mac_b    = (state_r == S_GLOB) ? loc_r[{k_r, c_r}] : bind_r[{k_r, c_r}];

  logic [BONE_W-1:0] gbone;
  assign gbone = bone_r[BONE_W-1:0];

  logic signed [31:0] res;
  assign res = sat_shift(acc);

  logic [MAX_BONES-1:0] keep_mask;
  always_comb begin
    for (int i = 0; i < MAX_BONES; i++) keep_mask[i] = (i < int'(in_ch.bone));
  end

  logic pdone;
  assign pdone = (in_ch.parent[6] == 1'b0) && (int'(in_ch.parent) < MAX_BONES) &&
                 keep_mask[in_ch.parent[BONE_W-1:0]] &&
                 done_r[in_ch.parent[BONE_W-1:0]];

  // Sequencer. Each MAC step takes phases 0 (read), 1 (issue); after k=3 the sum
  // settles through phases 2 and 3 and is written in phase 4.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= '0;
      out_v_r <= 1'b0;
      ph_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc_in && int'(in_ch.bone) < MAX_BONES) begin
            if (in_ch.cmd == CMD_LOCAL) begin
              loc_r[{in_ch.row, 2'd0}] <= in_ch.elem0;
              loc_r[{in_ch.row, 2'd1}] <= in_ch.elem1;
              loc_r[{in_ch.row, 2'd2}] <= in_ch.elem2;
              loc_r[{in_ch.row, 2'd3}] <= in_ch.elem3;
            end else begin
              bind_r[{in_ch.row, 2'd0}] <= in_ch.elem0;
              bind_r[{in_ch.row, 2'd1}] <= in_ch.elem1;
              bind_r[{in_ch.row, 2'd2}] <= in_ch.elem2;
              bind_r[{in_ch.row, 2'd3}] <= in_ch.elem3;
            end
            if (in_ch.cmd == CMD_BIND && in_ch.row == 2'd3) begin
              bone_r <= in_ch.bone;
              par_r  <= in_ch.parent;
              done_r <= done_r & keep_mask;
              err_r  <= !(in_ch.parent == -7'sd1) && !pdone;
              root_r <= !pdone;
              r_r <= '0; c_r <= '0; k_r <= '0; ph_r <= '0;
              state_r <= pdone ? S_GLOB : S_SKIN;
            end
          end
        end
        S_GLOB, S_SKIN: begin
          if (state_r == S_SKIN && ph_r == 3'd0 && k_r == 2'd0 && r_r == 2'd0 &&
              c_r == 2'd0 && root_r) begin
            // Root: global is the local matrix, copied into place.
            for (int i = 0; i < 16; i++) glob_r[i] <= loc_r[i];
            root_r <= 1'b0;
          end else if (ph_r == 3'd1 && k_r != 2'd3) begin
            k_r <= k_r + 2'd1; ph_r <= 3'd0;
          end else if (ph_r == 3'd4) begin
            ph_r <= 3'd0; k_r <= '0;
            if (state_r == S_GLOB) glob_r[{r_r, c_r}] <= res;
            else srow_r[c_r] <= res;
            c_r <= c_r + 2'd1;
            if (c_r == 2'd3) begin
              if (state_r == S_SKIN) begin
                state_r <= S_OUT;
                out_v_r <= 1'b1;
              end else begin
                r_r <= r_r + 2'd1;
                if (r_r == 2'd3) state_r <= S_SKIN;
              end
            end
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        S_OUT: begin
          if (out_v_r && out_ch.ready) begin
            out_v_r <= 1'b0;
            if (r_r == 2'd3) begin
              state_r <= S_IDLE;
              done_r[gbone] <= 1'b1;
            end else begin
              r_r <= r_r + 2'd1;
              state_r <= S_SKIN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Store the global matrix row by row while it is used in the skin pass.
  always_ff @(posedge clk) begin
    gs_waddr <= GS_AW'({gbone, r_r, c_r});
    gs_wdata <= glob_r[{r_r, c_r}];
  end
  logic gs_we_nxt;
  assign gs_we_nxt = (state_r == S_SKIN) && ph_r == 3'd0 && k_r == 2'd0 && !root_r;

  // Write enable drives in the cycle after the element address is chosen.
  logic gs_we_r;
  always_ff @(posedge clk) begin
    if (!rst_n) gs_we_r <= 1'b0;
    else        gs_we_r <= gs_we_nxt;
  end
  assign gs_we = gs_we_r;

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_bone     = bone_r;
  assign out_ch.out_row      = r_r;
  assign out_ch.val0         = srow_r[0];
  assign out_ch.val1         = srow_r[1];
  assign out_ch.val2         = srow_r[2];
  assign out_ch.val3         = srow_r[3];
  assign out_ch.last_row     = (r_r == 2'd3);
  assign out_ch.parent_error = err_r;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input ready while a result waits");
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.out_row))
    else $error("result row changed while stalled");
  a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_row) |=> in_ch.ready)
    else $error("block not idle after last row");
`endif

endmodule

// ===== rtl/bmpu_ram.sv =====
module bmpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bmpu_mac.sv =====
module bmpu_mac
  import bmpu_pkg::*;
(
  input  logic                    clk,
  input  logic                    clr,
  input  logic                    en,
  input  logic signed [31:0]      a,
  input  logic signed [31:0]      b,
  output logic signed [ACC_W-1:0] acc_r
);

  logic signed [63:0] prod_r;
  logic               prod_v_r;
  logic signed [ACC_W-1:0] acc_nxt;

  // A clear on the first product starts a fresh sum.
  logic clr_r;

  always_comb begin
    if (clr_r) acc_nxt = ACC_W'(prod_r);
    else       acc_nxt = acc_r + ACC_W'(prod_r);
  end

  // Product register, then accumulator.
  always_ff @(posedge clk) begin
    prod_r   <= a * b;
    prod_v_r <= en;
    clr_r    <= clr;
    if (prod_v_r) acc_r <= acc_nxt;
  end

endmodule

// ===== bench/bmpu_checker.sv =====
module bmpu_checker
  import bmpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bmpu_in_if        in_mon,
  bmpu_out_if       out_mon,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0] quad_t [4];

  typedef struct {
    logic [5:0]         bone;
    logic [1:0]         row;
    logic signed [31:0] v [4];
    logic               last;
    logic               perr;
  } skin_row_t;

  // Own copy of the block state.
  logic signed [31:0] global_mem [MAX_BONES][16];
  logic [MAX_BONES-1:0] computed;
  logic signed [31:0] local_rows [16];
  logic signed [31:0] bind_rows [16];
  skin_row_t skin_q [$];
  int errs;

  // Exact four-term dot product, floor shift, saturate to 32 bits.
  function automatic logic signed [31:0] fixed_dot(input quad_t a, input quad_t b);
    logic signed [67:0] acc;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc += 68'($signed(a[k])) * 68'($signed(b[k]));
    end
    acc = acc >>> FRAC_BITS;
    if (acc > 68'sh7fffffff) return 32'sh7fffffff;
    if (acc < -68'sh80000000) return 32'sh80000000;
    return acc[31:0];
  endfunction

  // Loads one row and, on the final bind row, queues the four skinning rows.
  task automatic predict_rows(input logic cmd, input logic [5:0] bone,
                              input logic signed [6:0] parent, input logic [1:0] row,
                              input quad_t e);
    logic signed [31:0] glob [16];
    quad_t a, b;
    logic err, root;
    skin_row_t s;
    for (int c = 0; c < 4; c++) begin
      if (cmd == CMD_BIND) bind_rows[row*4+c] = e[c];
      else local_rows[row*4+c] = e[c];
    end
    if (!(cmd == CMD_BIND && row == 2'd3)) return;
    for (int i = 0; i < MAX_BONES; i++) begin
      if (i >= bone) computed[i] = 1'b0;
    end
    err = 1'b0;
    root = 1'b0;
    if (parent == -7'sd1) begin
      root = 1'b1;
    end else if (parent < 0 || int'(parent) >= MAX_BONES || !computed[parent]) begin
      root = 1'b1;
      err = 1'b1;
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (root) begin
          glob[r*4+c] = local_rows[r*4+c];
        end else begin
          for (int k = 0; k < 4; k++) begin
            a[k] = global_mem[parent][r*4+k];
            b[k] = local_rows[k*4+c];
          end
          glob[r*4+c] = fixed_dot(a, b);
        end
      end
    end
    for (int i = 0; i < 16; i++) global_mem[bone][i] = glob[i];
    computed[bone] = 1'b1;
    for (int r = 0; r < 4; r++) begin
      s.bone = bone;
      s.row = 2'(r);
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          a[k] = glob[r*4+k];
          b[k] = bind_rows[k*4+c];
        end
        s.v[c] = fixed_dot(a, b);
      end
      s.last = (r == 3);
      s.perr = err;
      skin_q.push_back(s);
    end
  endtask

  task automatic compare_row();
    skin_row_t s;
    logic signed [31:0] got [4];
    got = '{out_mon.val0, out_mon.val1, out_mon.val2, out_mon.val3};
    if (skin_q.size() == 0) begin
      $display("%0t: unexpected result transfer bone %0d row %0d", $time,
               out_mon.out_bone, out_mon.out_row);
      errs++;
      return;
    end
    s = skin_q.pop_front();
    if (s.bone !== out_mon.out_bone || s.row !== out_mon.out_row ||
        s.last !== out_mon.last_row || s.perr !== out_mon.parent_error) begin
      $display({"%0t: header mismatch: expected bone %0d row %0d last %0b err %0b,",
                " got %0d %0d %0b %0b"},
               $time, s.bone, s.row, s.last, s.perr, out_mon.out_bone, out_mon.out_row,
               out_mon.last_row, out_mon.parent_error);
      errs++;
    end
    for (int c = 0; c < 4; c++) begin
      if (s.v[c] !== got[c]) begin
        $display("%0t: bone %0d row %0d column %0d: expected %h, got %h", $time,
                 s.bone, s.row, c, s.v[c], got[c]);
        errs++;
      end
    end
  endtask

  // Watch both channels at each edge; counts are published a step later.
  always @(posedge clk) begin
    if (!rst_n) begin
      computed = '0;
      skin_q.delete();
      errs = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_rows(in_mon.cmd, in_mon.bone, in_mon.parent, in_mon.row,
                     '{in_mon.elem0, in_mon.elem1, in_mon.elem2, in_mon.elem3});
      end
      if (out_mon.valid && out_mon.ready) compare_row();
    end
    fail_count <= errs;
    pending <= skin_q.size();
  end
endmodule

// ===== bench/tb_bone_matrix_palette_update.sv =====
module tb_bone_matrix_palette_update
  import bmpu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 500;
  localparam int QUIET_FROM = 440;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent;
  bit   quiet;
  bit   hold_request;
  bit   hold_done;
  logic [MAX_BONES-1:0] pass_done;

  bmpu_in_if  in_ch();
  bmpu_out_if out_ch();

  bone_matrix_palette_update dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmpu_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mix of saturating extremes, full random words and modest values.
  function automatic logic signed [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      3: return '0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Presents one row and holds it until the transfer, with optional idle first.
  task automatic send_row(input logic cmd, input logic [5:0] bone,
                          input logic signed [6:0] parent, input logic [1:0] row,
                          input bit rand_vals);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.bone   <= bone;
    in_ch.parent <= parent;
    in_ch.row    <= row;
    if (rand_vals) begin
      in_ch.elem0 <= pick_elem();
      in_ch.elem1 <= pick_elem();
      in_ch.elem2 <= pick_elem();
      in_ch.elem3 <= pick_elem();
    end
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (cmd == CMD_BIND && row == 2'd3) begin
      for (int i = 0; i < MAX_BONES; i++) begin
        if (i >= bone) pass_done[i] = 1'b0;
      end
      pass_done[bone] = 1'b1;
    end
    if (sent == 120) hold_request = 1'b1;
    if (sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic send_bone(input logic [5:0] bone, input logic signed [6:0] parent);
    for (int r = 0; r < 4; r++) send_row(CMD_LOCAL, bone, parent, 2'(r), 1'b1);
    for (int r = 0; r < 4; r++) send_row(CMD_BIND, bone, parent, 2'(r), 1'b1);
  endtask

  function automatic logic signed [6:0] pick_parent(input logic [5:0] bone);
    int picks [$];
    case ($urandom_range(0, 9))
      0: return -7'sd1;
      1: return 7'($urandom_range(0, 127));
      2: return {1'b0, bone};
      default: begin
        for (int i = 0; i < MAX_BONES; i++) if (pass_done[i] && i < bone) picks.push_back(i);
        if (picks.size() == 0) return -7'sd1;
        return 7'(picks[$urandom_range(0, picks.size() - 1)]);
      end
    endcase
  endfunction

  // Stimulus.
  initial begin
    int b;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_LOCAL;
    in_ch.bone <= '0;
    in_ch.parent <= -7'sd1;
    in_ch.row <= '0;
    in_ch.elem0 <= '0;
    in_ch.elem1 <= '0;
    in_ch.elem2 <= '0;
    in_ch.elem3 <= '0;
    sent = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    pass_done = '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a root, a child with saturating extremes, then repair cases.
    send_bone(6'd0, -7'sd1);
    for (int r = 0; r < 4; r++) begin
      in_ch.elem0 <= 32'sh7fffffff;
      in_ch.elem1 <= 32'sh80000000;
      in_ch.elem2 <= 32'sh7fffffff;
      in_ch.elem3 <= 32'sh80000000;
      send_row(CMD_LOCAL, 6'd1, 7'sd0, 2'(r), 1'b0);
    end
    for (int r = 0; r < 4; r++) send_row(CMD_BIND, 6'd1, 7'sd0, 2'(r), 1'b0);
    // Parent not yet computed, then self parent, then a negative non-root parent.
    send_row(CMD_BIND, 6'd63, 7'sd63, 2'd3, 1'b1);
    send_row(CMD_BIND, 6'd2, 7'sd2, 2'd3, 1'b1);
    // Restart at a lower bone begins a new pass, so bone 2 is no longer usable.
    send_row(CMD_BIND, 6'd1, -7'sd64, 2'd3, 1'b1);
    send_row(CMD_BIND, 6'd5, 7'sd2, 2'd3, 1'b1);
    send_row(CMD_BIND, 6'd6, 7'sd1, 2'd3, 1'b1);

    // Random passes of well-formed bones with some noise rows.
    while (sent < ITEM_TARGET) begin
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 2);
      while (b < MAX_BONES && sent < ITEM_TARGET) begin
        if ($urandom_range(0, 11) == 0) begin
          send_row(1'($urandom), 6'($urandom), 7'($urandom), 2'($urandom), 1'b1);
        end else begin
          send_bone(6'(b), pick_parent(6'(b)));
        end
        if (sent >= 250 && sent < 258) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
        b += $urandom_range(1, 3);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow the block to settle.
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bone_matrix_palette_update verification clean");
    end else begin
      $display("bone_matrix_palette_update verification failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, none near the end.
  initial begin
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("bone_matrix_palette_update verification failed");
        $finish;
      end
    end
  end
endmodule

// ===== filelist.f =====
rtl/bmpu_pkg.sv
rtl/bmpu_if.sv
rtl/bmpu_ram.sv
rtl/bmpu_mac.sv
rtl/bone_matrix_palette_update.sv
bench/bmpu_checker.sv
bench/tb_bone_matrix_palette_update.sv
